[hw/rtl/hnc_pkg.sv]
// Shared types and constants for the Hamming nearest-centroid core.
// Used by hnc_ctrl, hnc_datapath and hamming_nearest_centroid_core.
package hnc_pkg;

  localparam int MAX_CELLS_DEF  = 256;
  localparam int DIM_WORDS_DEF  = 4;

  // Fixed field widths of the streaming payload
  localparam int CELL_REQ_W     = 8;
  localparam int WORD_INDEX_W   = 2;
  localparam int DATA_W         = 64;
  localparam int NEAREST_W      = 8;
  localparam int DIST_W         = 9;
  localparam int CELLS_CFG_W    = 9;
  localparam int LEN_W          = 6;
  localparam int CFG_DATA_W     = 9;
  localparam int BYTES_PER_WORD = 8;

  // Widest internal indexes over the parameter ranges
  localparam int CELL_IDX_MAX_W = 12;
  localparam int WORD_IDX_MAX_W = 6;

  localparam logic ACT_CENTROID = 1'b0;
  localparam logic ACT_QUERY    = 1'b1;

  localparam logic REG_CELLS_IN_USE = 1'b0;
  localparam logic REG_DIM_BYTES    = 1'b1;

  typedef struct packed {
    logic                      wr_cent;
    logic                      wr_query;
    logic                      rd_valid;
    logic [CELL_IDX_MAX_W-1:0] rd_cell;
    logic [WORD_IDX_MAX_W-1:0] rd_word;
    logic [BYTES_PER_WORD-1:0] byte_en;
    logic                      first_word;
    logic                      last_word;
    logic                      first_cell;
    logic                      final_rd;
    logic                      load_out;
  } hnc_cmd_t;

  typedef struct packed {
    logic search_done;
  } hnc_status_t;

endpackage

[hw/rtl/hnc_datapath.sv]
// Datapath: centroid and query memories, XOR/popcount pipeline, running best.
// Depends on hnc_pkg; driven by hnc_ctrl through hnc_cmd_t.
module hnc_datapath import hnc_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int DIM_WORDS = DIM_WORDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  hnc_cmd_t                cmd,
  input  logic [CELL_REQ_W-1:0]   cell_req,
  input  logic [WORD_INDEX_W-1:0] word_index,
  input  logic [DATA_W-1:0]       data,
  output hnc_status_t             status,
  output logic [NEAREST_W-1:0]    nearest_cell,
  output logic [DIST_W-1:0]       min_distance
);

  localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int WORD_W = (DIM_WORDS > 1) ? $clog2(DIM_WORDS) : 1;
  localparam int ADDR_W = CELL_W + WORD_W;
  localparam int CENT_DEPTH = 2 ** ADDR_W;
  localparam int PC_W = 4;

  function automatic logic [PC_W-1:0] popcount8(input logic [7:0] v);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + PC_W'(v[i]);
    end
    return n;
  endfunction

  logic [DATA_W-1:0] cent_mem [CENT_DEPTH];
  logic [DATA_W-1:0] query_mem [DIM_WORDS];

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] q_wr_idx;
  logic [WORD_W-1:0] q_rd_idx;

  assign wr_addr  = {CELL_W'(cell_req), WORD_W'(word_index)};
  assign rd_addr  = {cmd.rd_cell[CELL_W-1:0], cmd.rd_word[WORD_W-1:0]};
  assign q_wr_idx = WORD_W'(word_index);
  assign q_rd_idx = cmd.rd_word[WORD_W-1:0];

  // Stage 1: registered memory reads with tags
  logic [DATA_W-1:0]         s1_cent;
  logic [DATA_W-1:0]         s1_query;
  logic                      s1_valid;
  logic [BYTES_PER_WORD-1:0] s1_byte_en;
  logic                      s1_first_word, s1_last_word, s1_first_cell, s1_final;
  logic [CELL_W-1:0]         s1_cell;

  always_ff @(posedge clk) begin
    if (cmd.wr_cent) begin
      cent_mem[wr_addr] <= data;
    end
    if (cmd.wr_query) begin
      query_mem[q_wr_idx] <= data;
    end
    s1_cent  <= cent_mem[rd_addr];
    s1_query <= query_mem[q_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_valid;
    end
    s1_byte_en    <= cmd.byte_en;
    s1_first_word <= cmd.first_word;
    s1_last_word  <= cmd.last_word;
    s1_first_cell <= cmd.first_cell;
    s1_final      <= cmd.final_rd;
    s1_cell       <= cmd.rd_cell[CELL_W-1:0];
  end

  // Stage 2: per-byte popcount of the masked difference
  logic [DATA_W-1:0]  diff;
  logic [PC_W-1:0]    s2_pc [BYTES_PER_WORD];
  logic               s2_valid;
  logic               s2_first_word, s2_last_word, s2_first_cell, s2_final;
  logic [CELL_W-1:0]  s2_cell;

  assign diff = s1_cent ^ s1_query;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      s2_pc[b] <= s1_byte_en[b] ? popcount8(diff[b*8 +: 8]) : '0;
    end
    s2_first_word <= s1_first_word;
    s2_last_word  <= s1_last_word;
    s2_first_cell <= s1_first_cell;
    s2_final      <= s1_final;
    s2_cell       <= s1_cell;
  end

  // Stage 3: accumulate per cell, keep the best (strict less keeps lowest index).
  // Masked length is at most 63 bytes, so the distance never exceeds 504.
  logic [DIST_W-1:0] acc;
  logic [DIST_W-1:0] acc_next;
  logic [DIST_W-1:0] word_sum;
  logic [DIST_W-1:0] best_distance;
  logic [NEAREST_W-1:0] best_index;
  logic              done;

  always_comb begin
    word_sum = '0;
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      word_sum = word_sum + DIST_W'(s2_pc[b]);
    end
    acc_next = (s2_first_word ? '0 : acc) + word_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= '0;
      best_index    <= '0;
      done          <= 1'b0;
    end else begin
      done <= s2_valid && s2_final;
      if (s2_valid && s2_last_word && (s2_first_cell || acc_next < best_distance)) begin
        best_distance <= acc_next;
        best_index    <= NEAREST_W'(s2_cell);
      end
    end
    if (s2_valid) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nearest_cell <= '0;
      min_distance <= '0;
    end else if (cmd.load_out) begin
      nearest_cell <= best_index;
      min_distance <= best_distance;
    end
  end

  assign status.search_done = done;

endmodule

[hw/rtl/hnc_ctrl.sv]
// Controller: input handshake, configuration registers, search sequencer, output valid.
// Depends on hnc_pkg; commands hnc_datapath through hnc_cmd_t.
module hnc_ctrl import hnc_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int DIM_WORDS = DIM_WORDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    s_tuser,
  input  logic                    s_tlast,
  input  logic [CELL_REQ_W-1:0]   cell_req,
  input  logic [WORD_INDEX_W-1:0] word_index,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  input  hnc_status_t             status,
  output hnc_cmd_t                cmd
);

  localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int WORD_W = (DIM_WORDS > 1) ? $clog2(DIM_WORDS) : 1;
  localparam int LEN_CAP = (DIM_WORDS * BYTES_PER_WORD > 63) ? 63 : DIM_WORDS * BYTES_PER_WORD;
  localparam logic [12:0] MaxCells13 = 13'(MAX_CELLS);
  localparam logic [6:0]  DimWords7  = 7'(DIM_WORDS);

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, RESULT} state_t;

  state_t                 state;
  logic [CELLS_CFG_W-1:0] cells_in_use;
  logic [LEN_W-1:0]       dim_bytes;
  logic [CELL_W-1:0]      cur_cell;
  logic [WORD_W-1:0]      word;
  logic [CELL_W-1:0]      last_cell;
  logic [6:0]             last_word;
  logic [LEN_W-1:0]       len;

  logic        accept;
  logic        start;
  logic [12:0] cells13;
  logic [CELL_W-1:0] last_cell_next;
  logic [LEN_W-1:0]  len_next;
  logic [6:0]  nwords;
  logic        word_end;
  logic        cell_end;
  logic        out_free;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign start    = accept && (s_tuser == ACT_QUERY) && s_tlast;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cells13 = 13'(cells_in_use);
    if (cells13 == 13'd0) begin
      cells13 = 13'd1;
    end else if (cells13 > MaxCells13) begin
      cells13 = MaxCells13;
    end
    last_cell_next = CELL_W'(cells13 - 13'd1);
    len_next = (dim_bytes > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : dim_bytes;
    // Only words holding unmasked bytes are walked; zero length still walks one.
    nwords = (7'(len_next) + 7'd7) >> 3;
    if (nwords == 7'd0) begin
      nwords = 7'd1;
    end
  end

  assign word_end = (7'(word) == last_word);
  assign cell_end = (cur_cell == last_cell);

  always_comb begin
    cmd = '0;
    cmd.wr_cent  = accept && (s_tuser == ACT_CENTROID)
                   && (13'(cell_req) < MaxCells13) && (7'(word_index) < DimWords7);
    cmd.wr_query = accept && (s_tuser == ACT_QUERY) && (7'(word_index) < DimWords7);
    cmd.rd_valid   = (state == RUN);
    cmd.rd_cell    = CELL_IDX_MAX_W'(cur_cell);
    cmd.rd_word    = WORD_IDX_MAX_W'(word);
    cmd.first_word = (word == '0);
    cmd.last_word  = word_end;
    cmd.first_cell = (cur_cell == '0);
    cmd.final_rd   = word_end && cell_end;
    cmd.load_out   = (state == RESULT) && out_free;
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      cmd.byte_en[b] = (9'({word, 3'(b)}) < 9'(len));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      cells_in_use <= CELLS_CFG_W'(1);
      dim_bytes    <= LEN_W'(32);
      cur_cell     <= '0;
      word         <= '0;
      last_cell    <= '0;
      last_word    <= '0;
      len          <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CELLS_IN_USE: cells_in_use <= cfg_data;
          REG_DIM_BYTES:    dim_bytes    <= cfg_data[LEN_W-1:0];
          default:          ;
        endcase
      end

      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (start) begin
            cur_cell  <= '0;
            word      <= '0;
            last_cell <= last_cell_next;
            last_word <= nwords - 7'd1;
            len       <= len_next;
            state     <= RUN;
          end
        end
        RUN: begin
          if (word_end) begin
            word <= '0;
            if (cell_end) begin
              state <= DRAIN;
            end else begin
              cur_cell <= cur_cell + 1'b1;
            end
          end else begin
            word <= word + 1'b1;
          end
        end
        DRAIN: begin
          if (status.search_done) begin
            state <= RESULT;
          end
        end
        RESULT: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/hamming_nearest_centroid_core.sv]
// Hamming nearest-centroid core: a centroid write or a non-last query word is just stored.
// A query's last word starts a search of ceil(len/8) words per cell in use, at least one
// (one 64-bit word per cycle from the centroid memory read port, len = dim_bytes capped
// at min(63, 8*DIM_WORDS)); the result passes pipeline, drain and output load. s_tready is
// low from the last word until it is offered, longer while an earlier result still waits.
// Reset (sync, active high): idle, no result pending, cells_in_use = 1, dim_bytes = 32.
module hamming_nearest_centroid_core import hnc_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int DIM_WORDS = DIM_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [79:0]           s_tdata,   // cell_req[7:0], word_index[9:8], data[73:10]
  input  logic                  s_tuser,   // action
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata    // nearest_cell[7:0], min_distance[16:8]
);

  hnc_cmd_t    cmd;
  hnc_status_t status;

  logic [CELL_REQ_W-1:0]   cell_req;
  logic [WORD_INDEX_W-1:0] word_index;
  logic [DATA_W-1:0]       data;
  logic [NEAREST_W-1:0]    nearest_cell;
  logic [DIST_W-1:0]       min_distance;

  assign cell_req   = s_tdata[7:0];
  assign word_index = s_tdata[9:8];
  assign data       = s_tdata[73:10];
  assign m_tdata    = {7'd0, min_distance, nearest_cell};

  hnc_ctrl #(
    .MAX_CELLS(MAX_CELLS),
    .DIM_WORDS(DIM_WORDS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .cell_req   (cell_req),
    .word_index (word_index),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .status     (status),
    .cmd        (cmd)
  );

  hnc_datapath #(
    .MAX_CELLS(MAX_CELLS),
    .DIM_WORDS(DIM_WORDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cell_req     (cell_req),
    .word_index   (word_index),
    .data         (data),
    .status       (status),
    .nearest_cell (nearest_cell),
    .min_distance (min_distance)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for hamming_nearest_centroid_core: streams centroid loads and query words,
// keeps its own copy of the centroid table and query buffer, and checks every search result.
// Depends on hnc_pkg and the core RTL only.
module tb;
  import hnc_pkg::*;

  localparam int CELLS       = MAX_CELLS_DEF;
  localparam int WORDS       = DIM_WORDS_DEF;
  localparam int LIMIT       = 2_000_000;
  localparam int SETTLE      = 20;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic        action;
    logic [7:0]  cell_req;
    logic [1:0]  word_index;
    logic [63:0] data;
    logic        last;
  } vec_word_t;

  typedef struct {
    logic [7:0] idx;
    logic [8:0] distance;
  } nearest_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_index = REG_CELLS_IN_USE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [79:0]           s_tdata   = '0;  // cell_req[7:0], word_index[9:8], data[73:10]
  logic                  s_tuser   = 1'b0; // action
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;          // nearest_cell[7:0], min_distance[16:8]

  // shadow of the block's table, query buffer and registers
  bit [63:0]   cent_mem [CELLS][WORDS];
  bit [63:0]   query_words [WORDS];
  int unsigned cells_cfg = 1;
  int unsigned len_cfg   = 32;

  vec_word_t word_q[$];
  nearest_t  nearest_q[$];
  vec_word_t cur_word;
  int        mismatches = 0;
  int        cycles     = 0;
  logic      no_gaps    = 1'b0;
  logic      hold_go    = 1'b0;
  logic      hold_done  = 1'b0;
  int        hold_cnt   = 0;

  hamming_nearest_centroid_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned used_cells();
    if (cells_cfg == 0) return 1;
    if (cells_cfg > CELLS) return CELLS;
    return cells_cfg;
  endfunction

  function automatic logic [63:0] byte_mask(int unsigned w, int unsigned len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < BYTES_PER_WORD; b++)
      if (w * BYTES_PER_WORD + b < len) m[b*8 +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic nearest_t search_nearest();
    nearest_t    best;
    int unsigned len, hd;
    len  = (len_cfg > WORDS * BYTES_PER_WORD) ? WORDS * BYTES_PER_WORD : len_cfg;
    best = '{idx: 8'd0, distance: 9'd0};
    for (int c = 0; c < used_cells(); c++) begin
      hd = 0;
      for (int w = 0; w < WORDS; w++)
        hd += $countones((query_words[w] ^ cent_mem[c][w]) & byte_mask(w, len));
      if (hd > 511) hd = 511;
      // strict compare: lowest index keeps a tie
      if (c == 0 || hd < best.distance) begin
        best.idx      = c[7:0];
        best.distance = hd[8:0];
      end
    end
    return best;
  endfunction

  function automatic void apply_word(vec_word_t v);
    if (v.action == ACT_CENTROID) begin
      cent_mem[v.cell_req][v.word_index] = v.data;
    end else begin
      query_words[v.word_index] = v.data;
      if (v.last) nearest_q = {nearest_q, search_nearest()};
    end
  endfunction

  function automatic void push_word(logic act, logic [7:0] cidx, logic [1:0] widx,
                                    logic [63:0] d, logic lst);
    vec_word_t v;
    v.action     = act;
    v.cell_req   = cidx;
    v.word_index = widx;
    v.data       = d;
    v.last       = lst;
    word_q = {word_q, v};
  endfunction

  // One stimulus unit: a centroid write, a lone query word, or a complete query whose
  // words often sit near a centroid in use so that close distances and ties come up.
  function automatic int push_unit();
    int        r, n, s, pick;
    vec_word_t v;
    r            = $urandom_range(0, 99);
    v.cell_req   = 8'($urandom_range(0, 255));
    v.word_index = 2'($urandom_range(0, WORDS - 1));
    v.data       = {$urandom, $urandom};
    v.last       = 1'($urandom_range(0, 1));
    if (r < 20) begin
      v.action = ACT_CENTROID;
      if (r < 10) v.cell_req = 8'($urandom_range(0, used_cells() - 1));
      word_q = {word_q, v};
      return 1;
    end
    v.action = ACT_QUERY;
    if (r >= 85) begin
      word_q = {word_q, v};
      return 1;
    end
    n    = $urandom_range(1, WORDS);
    s    = $urandom_range(0, WORDS - 1);
    pick = $urandom_range(0, used_cells() - 1);
    for (int i = 0; i < n; i++) begin
      v.word_index = 2'((s + i) % WORDS);
      v.cell_req   = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0: v.data = {$urandom, $urandom};
        1: v.data = cent_mem[pick][v.word_index];
        default: v.data = cent_mem[pick][v.word_index] ^ (64'd1 << $urandom_range(0, 63));
      endcase
      v.last = (i == n - 1);
      word_q = {word_q, v};
    end
    return n;
  endfunction

  // idle: nothing queued or offered, no result outstanding, then let the core drain
  task automatic settle();
    do @(negedge clk); while (word_q.size() != 0 || s_tvalid || nearest_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_regs(int unsigned c, int unsigned l);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CELLS_IN_USE;
    cfg_data  <= c[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_DIM_BYTES;
    cfg_data  <= l[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cells_cfg = c & 9'h1FF;
    len_cfg   = l & 6'h3F;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_word(cur_word);
      if (!s_tvalid || s_tready) begin
        if (word_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 15)) begin
          cur_word = word_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, cur_word.data, cur_word.word_index, cur_word.cell_req};
          s_tuser  <= cur_word.action;
          s_tlast  <= cur_word.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off so the core backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin : result_check
    nearest_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (nearest_q.size() == 0) begin
        $error("unexpected result transaction: nearest_cell %0d min_distance %0d",
               m_tdata[7:0], m_tdata[16:8]);
        mismatches++;
      end else begin
        exp_r = nearest_q.pop_front();
        if (m_tdata[7:0] !== exp_r.idx) begin
          $error("nearest_cell: expected %0d, actual %0d", exp_r.idx, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[16:8] !== exp_r.distance) begin
          $error("min_distance: expected %0d, actual %0d", exp_r.distance, m_tdata[16:8]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned c_val, d_val;
    int          quota, n_items;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one cell, full length
    for (int w = 0; w < WORDS; w++) begin
      push_word(ACT_CENTROID, 8'd0, 2'(w), '1, w == 2);  // last is ignored on loads
      push_word(ACT_CENTROID, 8'd1, 2'(w), '1, 1'b0);
    end
    push_word(ACT_CENTROID, 8'd255, 2'd3, '0, 1'b1);
    for (int w = 0; w < WORDS; w++)
      push_word(ACT_QUERY, 8'd0, 2'(w), '0, w == WORDS - 1);  // every bit differs
    push_word(ACT_QUERY, 8'd255, 2'd0, '1, 1'b1);             // upper words stale

    // partial word: cells 0 and 1 tie, then cell 1 moves closer
    settle();
    set_regs(2, 5);
    push_word(ACT_QUERY, 8'd0, 2'd0, '0, 1'b1);
    push_word(ACT_CENTROID, 8'd1, 2'd0, 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
    push_word(ACT_QUERY, 8'd0, 2'd0, '0, 1'b1);

    // zero cells acts as one, zero length masks everything
    settle();
    set_regs(0, 0);
    push_word(ACT_QUERY, 8'd17, 2'd2, {$urandom, $urandom}, 1'b1);

    // load the whole table so any cell count reads written entries
    settle();
    for (int c = 0; c < CELLS; c++)
      for (int w = 0; w < WORDS; w++)
        push_word(ACT_CENTROID, 8'(c), 2'(w), {$urandom, $urandom},
                  1'($urandom_range(0, 1)));

    settle();
    set_regs(511, 63);  // both registers past their top
    repeat (4) void'(push_unit());
    settle();
    set_regs(CELLS, WORDS * BYTES_PER_WORD);
    repeat (4) void'(push_unit());

    for (int p = 0; p < 20; p++) begin
      settle();
      no_gaps <= (p == 6);
      case ($urandom_range(0, 9))
        0: c_val = 0;
        1: c_val = $urandom_range(CELLS + 1, 511);
        2: c_val = $urandom_range(17, 64);
        default: c_val = $urandom_range(1, 16);
      endcase
      // short searches during the hold-off so results pile up behind it
      if (p == 3) c_val = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0: d_val = 0;
        1: d_val = $urandom_range(WORDS * BYTES_PER_WORD + 1, 63);
        default: d_val = $urandom_range(1, WORDS * BYTES_PER_WORD);
      endcase
      set_regs(c_val, d_val);
      if (p == 3) hold_go <= 1'b1;
      // full-table searches are slow, keep those phases short
      quota   = (used_cells() > 64) ? 15 : 50;
      n_items = 0;
      while (n_items < quota) n_items += push_unit();
    end

    settle();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
